// ----- sv/mfr_pkg.sv -----
// Shared types and constants of the matrix factorization recommender.
// No dependencies; used by mfr_mac, the top level, mfr_cfg_if and the testbench.
package mfr_pkg;

  // Load and run commands carried by one input item.
  typedef enum logic [1:0] {
    OP_WR_RATING = 2'd0,
    OP_WR_USER   = 2'd1,
    OP_WR_ITEM   = 2'd2,
    OP_RUN       = 2'd3
  } mfr_op_e;

  typedef struct packed {
    mfr_op_e            op;
    logic [5:0]         user_index;
    logic [5:0]         item_index;
    logic [2:0]         feature_index;
    logic signed [31:0] value;
  } mfr_in_t;

  typedef struct packed {
    logic [5:0] user_out;
    logic [5:0] recommended_item;
    logic       last_user;
  } mfr_out_t;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT      = 3'd4;

  // Commands to the shared multiply-accumulate unit.
  typedef enum logic [3:0] {
    MAC_NONE,
    MAC_CLR,
    MAC_MUL_UV,
    MAC_ACC_PRED,
    MAC_ERR,
    MAC_MUL_EF,
    MAC_ACC_GRAD,
    MAC_GCLAMP,
    MAC_MUL_LO,
    MAC_MUL_HI,
    MAC_SUM
  } mfr_mac_op_e;

  typedef struct packed {
    mfr_mac_op_e op;
    logic        user_mode;  // 1: updating user factors, 0: item factors
  } mfr_mac_ctl_t;

endpackage

// ----- sv/mfr_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is set where it is instantiated.
interface mfr_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/mfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/mfr_mac.sv -----
// Shared arithmetic unit: one 33x33 multiplier, a 64-bit accumulator,
// error, gradient clamp and update saturation. Uses mfr_pkg.
module mfr_mac (
  input  logic                 clk_i,
  input  mfr_pkg::mfr_mac_ctl_t ctl_i,
  input  logic [15:0]          lr_i,
  input  logic signed [31:0]   r_i,
  input  logic signed [31:0]   p_i,
  input  logic signed [31:0]   u_i,
  input  logic signed [31:0]   v_i,
  output logic signed [31:0]   pred_o,
  output logic signed [31:0]   upd_o
);
  import mfr_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  logic signed [63:0] acc_q, acc_d, prod_q;
  logic signed [31:0] e_q, e_d, f_q, f_d, old_q, old_d;
  logic               rpos_q, rpos_d;
  logic signed [47:0] g_q, g_d;
  logic signed [32:0] ma, mb, diff;
  logic signed [65:0] mprod;

  always_comb begin
    acc_d  = acc_q;
    e_d    = e_q;
    f_d    = f_q;
    old_d  = old_q;
    rpos_d = rpos_q;
    g_d    = g_q;
    ma     = '0;
    mb     = '0;
    diff   = {r_i[31], r_i} - {p_i[31], p_i};
    case (ctl_i.op)
      MAC_CLR: begin
        acc_d = '0;
      end
      MAC_MUL_UV: begin
        ma = {u_i[31], u_i};
        mb = {v_i[31], v_i};
      end
      MAC_ACC_PRED: begin
        acc_d = acc_q + (prod_q >>> 16);
      end
      MAC_ERR: begin
        e_d    = sat32({{31{diff[32]}}, diff});
        f_d    = ctl_i.user_mode ? v_i : u_i;
        rpos_d = !r_i[31] && (r_i != 32'sd0);
      end
      MAC_MUL_EF: begin
        ma = {e_q[31], e_q};
        mb = {f_q[31], f_q};
      end
      MAC_ACC_GRAD: begin
        if (rpos_q) begin
          acc_d = acc_q + ((prod_q >>> 16) <<< 1);
        end
      end
      MAC_GCLAMP: begin
        if (acc_q > 64'sh0000_7FFF_FFFF_FFFF) g_d = 48'sh7FFF_FFFF_FFFF;
        else if (acc_q < -64'sh0000_8000_0000_0000) g_d = 48'sh8000_0000_0000;
        else g_d = acc_q[47:0];
      end
      MAC_MUL_LO: begin
        ma    = {17'd0, lr_i};
        mb    = {9'd0, g_q[23:0]};
        old_d = ctl_i.user_mode ? u_i : v_i;
      end
      MAC_MUL_HI: begin
        ma    = {17'd0, lr_i};
        mb    = {{9{g_q[47]}}, g_q[47:24]};
        acc_d = prod_q;
      end
      MAC_SUM: begin
        acc_d = acc_q + (prod_q <<< 24);
      end
      default: begin
      end
    endcase
    mprod = ma * mb;
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= mprod[63:0];
    e_q    <= e_d;
    f_q    <= f_d;
    old_q  <= old_d;
    rpos_q <= rpos_d;
    g_q    <= g_d;
  end

  assign pred_o = sat32(acc_q);
  assign upd_o  = sat32($signed({{32{old_q[31]}}, old_q}) + (acc_q >>> 16));
endmodule

// ----- sv/matrix_factorization_recommender.sv -----
// Top level of the matrix factorization recommender: sequencer, stores.
// Uses mfr_pkg, mfr_stream_if, mfr_ram and mfr_mac.
//
// Load items (write rating, user factor, item factor) give no result. A
// run item forms predictions P = U*V, does iteration_count batch gradient
// passes (each followed by new predictions) and then emits one item per user
// in use with its best unrated item. All arithmetic goes through one 33x33
// multiplier with a 64-bit accumulator, and every store is a one-read-port
// RAM. The block takes no item during a run. After reset the rating store
// is cleared one entry a cycle, all 2^(clog2(MAX_USERS)+clog2(MAX_ITEMS))
// entries (4096 by default), before the first item is taken; configuration
// writes are taken at any time but must only be issued while idle.
module matrix_factorization_recommender #(
  parameter int unsigned MAX_USERS    = 64,
  parameter int unsigned MAX_ITEMS    = 64,
  parameter int unsigned MAX_FEATURES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mfr_stream_if.sink                     in_i,
  mfr_stream_if.source                   out_o
);
  import mfr_pkg::*;

  localparam int unsigned UW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned UMAX = (MAX_USERS < 64) ? MAX_USERS : 64;
  localparam int unsigned RD   = 1 << (UW + IW);
  localparam int unsigned UFD  = 1 << (UW + FW);
  localparam int unsigned VFD  = 1 << (FW + IW);

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_CLEAR    = 20'h00002,
    S_PR_RD    = 20'h00004,
    S_PR_MUL   = 20'h00008,
    S_PR_ACC   = 20'h00010,
    S_PR_WR    = 20'h00020,
    S_GR_RD    = 20'h00040,
    S_GR_ERR   = 20'h00080,
    S_GR_MUL   = 20'h00100,
    S_GR_ACC   = 20'h00200,
    S_AP_CLAMP = 20'h00400,
    S_AP_LO    = 20'h00800,
    S_AP_HI    = 20'h01000,
    S_AP_SUM   = 20'h02000,
    S_AP_WR    = 20'h04000,
    S_CP_RD    = 20'h08000,
    S_CP_WR    = 20'h10000,
    S_RC_RD    = 20'h20000,
    S_RC_CMP   = 20'h40000,
    S_OUT      = 20'h80000
  } state_e;

  // Configuration registers
  logic [15:0] lr_q, iter_q;
  logic [3:0]  fcnt_q;
  logic [6:0]  ucnt_q, icnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= 16'd655;
      iter_q <= 16'd1;
      fcnt_q <= 4'd2;
      ucnt_q <= 7'd64;
      icnt_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEARNING_RATE:   lr_q   <= cfg_wdata_i;
        CFG_ITERATION_COUNT: iter_q <= cfg_wdata_i;
        CFG_FEATURE_COUNT:   fcnt_q <= cfg_wdata_i[3:0];
        CFG_USER_COUNT:      ucnt_q <= cfg_wdata_i[6:0];
        CFG_ITEM_COUNT:      icnt_q <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Counts in use: zero counts as one, large values clamp to the store size.
  logic [10:0] nu_w, ni_w, nf_w;
  logic [UW:0] nu, nu_m1;
  logic [IW:0] ni, ni_m1;
  logic [FW:0] nf, nf_m1;

  always_comb begin
    if (ucnt_q == 7'd0) nu_w = 11'd1;
    else if (11'(ucnt_q) > 11'(UMAX)) nu_w = 11'(UMAX);
    else nu_w = 11'(ucnt_q);
    if (icnt_q == 7'd0) ni_w = 11'd1;
    else if (11'(icnt_q) > 11'(MAX_ITEMS)) ni_w = 11'(MAX_ITEMS);
    else ni_w = 11'(icnt_q);
    if (fcnt_q == 4'd0) nf_w = 11'd1;
    else if (11'(fcnt_q) > 11'(MAX_FEATURES)) nf_w = 11'(MAX_FEATURES);
    else nf_w = 11'(fcnt_q);
  end

  assign nu    = nu_w[UW:0];
  assign ni    = ni_w[IW:0];
  assign nf    = nf_w[FW:0];
  assign nu_m1 = nu - {{UW{1'b0}}, 1'b1};
  assign ni_m1 = ni - {{IW{1'b0}}, 1'b1};
  assign nf_m1 = nf - {{FW{1'b0}}, 1'b1};

  // Load decode
  logic          in_acc, u_ok, i_ok, f_ok;
  logic [10:0]   u_ext, i_ext, f_ext;
  logic [UW-1:0] u_idx;
  logic [IW-1:0] i_idx;
  logic [FW-1:0] f_idx;

  assign in_acc = in_i.valid && in_i.ready;
  assign u_ext  = 11'(in_i.data.user_index);
  assign i_ext  = 11'(in_i.data.item_index);
  assign f_ext  = 11'(in_i.data.feature_index);
  assign u_ok   = u_ext < 11'(MAX_USERS);
  assign i_ok   = i_ext < 11'(MAX_ITEMS);
  assign f_ok   = f_ext < 11'(MAX_FEATURES);
  assign u_idx  = u_ext[UW-1:0];
  assign i_idx  = i_ext[IW-1:0];
  assign f_idx  = f_ext[FW-1:0];

  // Sequencer state
  state_e          state_q, state_d;
  logic [UW-1:0]   ic_q, ic_d;
  logic [IW-1:0]   jc_q, jc_d;
  logic [FW-1:0]   kc_q, kc_d;
  logic [15:0]     pc_q, pc_d;
  logic            umode_q, umode_d;
  logic [UW+IW-1:0] clr_q, clr_d;
  logic signed [31:0] best_q, best_d;
  logic [IW-1:0]   pick_q, pick_d;
  mfr_out_t        out_q, out_d;
  mfr_mac_op_e     mac_op;
  mfr_mac_ctl_t    mac_ctl;

  logic i_last, j_last, k_last, better;
  logic [31:0] r_dout, p_dout, u_dout, v_dout, nu_dout, nv_dout;
  logic signed [31:0] pred_val, upd_val;
  logic [10:0] ic_ext, jc_ext, pick_ext;

  assign i_last = ({1'b0, ic_q} == nu_m1);
  assign j_last = ({1'b0, jc_q} == ni_m1);
  assign k_last = ({1'b0, kc_q} == nf_m1);
  assign better = (r_dout == 32'd0) && ($signed(p_dout) > best_q);
  assign ic_ext = 11'(ic_q);
  assign jc_ext = 11'(jc_q);
  assign pick_ext = 11'(pick_q);

  always_comb begin
    state_d = state_q;
    ic_d    = ic_q;
    jc_d    = jc_q;
    kc_d    = kc_q;
    pc_d    = pc_q;
    umode_d = umode_q;
    clr_d   = clr_q;
    best_d  = best_q;
    pick_d  = pick_q;
    out_d   = out_q;
    mac_op  = MAC_NONE;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && in_i.data.op == OP_RUN) begin
          ic_d    = '0;
          jc_d    = '0;
          kc_d    = '0;
          pc_d    = '0;
          umode_d = 1'b0;
          state_d = S_PR_RD;
        end
      end
      // prediction sweep: users, items, features innermost
      S_PR_RD: begin
        if (kc_q == '0) mac_op = MAC_CLR;
        state_d = S_PR_MUL;
      end
      S_PR_MUL: begin
        mac_op  = MAC_MUL_UV;
        state_d = S_PR_ACC;
      end
      S_PR_ACC: begin
        mac_op = MAC_ACC_PRED;
        if (k_last) begin
          state_d = S_PR_WR;
        end else begin
          kc_d    = kc_q + 1'b1;
          state_d = S_PR_RD;
        end
      end
      S_PR_WR: begin
        kc_d    = '0;
        state_d = S_PR_RD;
        if (j_last) begin
          jc_d = '0;
          if (i_last) begin
            ic_d    = '0;
            state_d = (pc_q < iter_q) ? S_GR_RD : S_RC_RD;
          end else begin
            ic_d = ic_q + 1'b1;
          end
        end else begin
          jc_d = jc_q + 1'b1;
        end
      end
      // gradient: inner loop over users (item mode) or items (user mode)
      S_GR_RD: begin
        if (umode_q ? (jc_q == '0) : (ic_q == '0)) mac_op = MAC_CLR;
        state_d = S_GR_ERR;
      end
      S_GR_ERR: begin
        mac_op  = MAC_ERR;
        state_d = S_GR_MUL;
      end
      S_GR_MUL: begin
        mac_op  = MAC_MUL_EF;
        state_d = S_GR_ACC;
      end
      S_GR_ACC: begin
        mac_op  = MAC_ACC_GRAD;
        state_d = S_GR_RD;
        if (umode_q) begin
          if (j_last) begin
            jc_d    = '0;
            state_d = S_AP_CLAMP;
          end else begin
            jc_d = jc_q + 1'b1;
          end
        end else begin
          if (i_last) begin
            ic_d    = '0;
            state_d = S_AP_CLAMP;
          end else begin
            ic_d = ic_q + 1'b1;
          end
        end
      end
      S_AP_CLAMP: begin
        mac_op  = MAC_GCLAMP;
        state_d = S_AP_LO;
      end
      S_AP_LO: begin
        mac_op  = MAC_MUL_LO;
        state_d = S_AP_HI;
      end
      S_AP_HI: begin
        mac_op  = MAC_MUL_HI;
        state_d = S_AP_SUM;
      end
      S_AP_SUM: begin
        mac_op  = MAC_SUM;
        state_d = S_AP_WR;
      end
      S_AP_WR: begin
        state_d = S_GR_RD;
        if (!umode_q) begin
          if (j_last) begin
            jc_d    = '0;
            umode_d = 1'b1;
          end else begin
            jc_d = jc_q + 1'b1;
          end
        end else if (i_last) begin
          ic_d    = '0;
          umode_d = 1'b0;
          if (k_last) begin
            kc_d    = '0;
            state_d = S_CP_RD;
          end else begin
            kc_d = kc_q + 1'b1;
          end
        end else begin
          ic_d = ic_q + 1'b1;
        end
      end
      // copy new factors over the old ones
      S_CP_RD: begin
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        state_d = S_CP_RD;
        if (!umode_q) begin
          if (j_last) begin
            jc_d    = '0;
            umode_d = 1'b1;
          end else begin
            jc_d = jc_q + 1'b1;
          end
        end else if (i_last) begin
          ic_d    = '0;
          umode_d = 1'b0;
          if (k_last) begin
            kc_d    = '0;
            pc_d    = pc_q + 1'b1;
            state_d = S_PR_RD;
          end else begin
            kc_d = kc_q + 1'b1;
          end
        end else begin
          ic_d = ic_q + 1'b1;
        end
      end
      // recommendation scan per user
      S_RC_RD: begin
        if (jc_q == '0) begin
          best_d = '0;
          pick_d = '0;
        end
        state_d = S_RC_CMP;
      end
      S_RC_CMP: begin
        if (better) begin
          best_d = $signed(p_dout);
          pick_d = jc_q;
        end
        if (j_last) begin
          jc_d                   = '0;
          out_d.user_out         = ic_ext[5:0];
          out_d.recommended_item = better ? jc_ext[5:0] : pick_ext[5:0];
          out_d.last_user        = i_last;
          state_d                = S_OUT;
        end else begin
          jc_d    = jc_q + 1'b1;
          state_d = S_RC_RD;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (i_last) begin
            ic_d    = '0;
            state_d = S_IDLE;
          end else begin
            ic_d    = ic_q + 1'b1;
            state_d = S_RC_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ic_q    <= '0;
      jc_q    <= '0;
      kc_q    <= '0;
      pc_q    <= '0;
      umode_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      ic_q    <= ic_d;
      jc_q    <= jc_d;
      kc_q    <= kc_d;
      pc_q    <= pc_d;
      umode_q <= umode_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    pick_q <= pick_d;
    out_q  <= out_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = out_q;

  // Stores and their write ports
  logic idle_ld;
  logic r_we, u_we, v_we, p_we, nu_we, nv_we;
  logic [UW+IW-1:0] r_waddr;
  logic [UW+FW-1:0] u_waddr;
  logic [FW+IW-1:0] v_waddr;
  logic [31:0] r_wdata, u_wdata, v_wdata;

  assign idle_ld = in_acc && (state_q == S_IDLE);
  assign r_we    = (state_q == S_CLEAR) ||
                   (idle_ld && in_i.data.op == OP_WR_RATING && u_ok && i_ok);
  assign r_waddr = (state_q == S_CLEAR) ? clr_q : {u_idx, i_idx};
  assign r_wdata = (state_q == S_CLEAR) ? 32'd0 : in_i.data.value;

  assign u_we    = (idle_ld && in_i.data.op == OP_WR_USER && u_ok && f_ok) ||
                   (state_q == S_CP_WR && umode_q);
  assign u_waddr = idle_ld ? {u_idx, f_idx} : {ic_q, kc_q};
  assign u_wdata = idle_ld ? in_i.data.value : nu_dout;

  assign v_we    = (idle_ld && in_i.data.op == OP_WR_ITEM && f_ok && i_ok) ||
                   (state_q == S_CP_WR && !umode_q);
  assign v_waddr = idle_ld ? {f_idx, i_idx} : {kc_q, jc_q};
  assign v_wdata = idle_ld ? in_i.data.value : nv_dout;

  assign p_we  = (state_q == S_PR_WR);
  assign nu_we = (state_q == S_AP_WR) && umode_q;
  assign nv_we = (state_q == S_AP_WR) && !umode_q;

  mfr_ram #(.WIDTH(32), .DEPTH(RD)) u_rat_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i({ic_q, jc_q}), .rdata_o(r_dout)
  );

  mfr_ram #(.WIDTH(32), .DEPTH(RD)) u_pred_ram (
    .clk_i, .we_i(p_we), .waddr_i({ic_q, jc_q}), .wdata_i(pred_val),
    .raddr_i({ic_q, jc_q}), .rdata_o(p_dout)
  );

  mfr_ram #(.WIDTH(32), .DEPTH(UFD)) u_uf_ram (
    .clk_i, .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i({ic_q, kc_q}), .rdata_o(u_dout)
  );

  mfr_ram #(.WIDTH(32), .DEPTH(VFD)) u_vf_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i({kc_q, jc_q}), .rdata_o(v_dout)
  );

  mfr_ram #(.WIDTH(32), .DEPTH(UFD)) u_nuf_ram (
    .clk_i, .we_i(nu_we), .waddr_i({ic_q, kc_q}), .wdata_i(upd_val),
    .raddr_i({ic_q, kc_q}), .rdata_o(nu_dout)
  );

  mfr_ram #(.WIDTH(32), .DEPTH(VFD)) u_nvf_ram (
    .clk_i, .we_i(nv_we), .waddr_i({kc_q, jc_q}), .wdata_i(upd_val),
    .raddr_i({kc_q, jc_q}), .rdata_o(nv_dout)
  );

  // Shared multiply-accumulate unit
  assign mac_ctl.op        = mac_op;
  assign mac_ctl.user_mode = umode_q;

  mfr_mac u_mac (
    .clk_i,
    .ctl_i  (mac_ctl),
    .lr_i   (lr_q),
    .r_i    (r_dout),
    .p_i    (p_dout),
    .u_i    (u_dout),
    .v_i    (v_dout),
    .pred_o (pred_val),
    .upd_o  (upd_val)
  );

`ifndef ASSERT_OFF
  // Never take a new item while a result is on offer.
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while result pending");

  // The final user's result ends the run.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last_user) |=> in_i.ready)
    else $error("block not idle after last result");

  // Ratings only change through a load item or the clearing pass.
  a_rat_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_we && state_q != S_CLEAR) |-> in_acc)
    else $error("rating store written during a run");
`endif
endmodule

// ----- bench/mfr_tb_pkg.sv -----
// Bench-side constants of the matrix factorization recommender testbench.
// No dependencies; imported by matrix_factorization_recommender_tb.
package mfr_tb_pkg;

  // Store sizes of the block under test (its default parameters).
  localparam int NU_MAX = 64;
  localparam int NI_MAX = 64;
  localparam int NF_MAX = 8;

endpackage

// ----- bench/mfr_tb_if.sv -----
// Configuration write port of the block, bundled for the testbench.
// Uses mfr_pkg for the index and data widths.
interface mfr_cfg_if;
  logic                           we;
  logic [mfr_pkg::CFG_IDX_W-1:0]  idx;
  logic [mfr_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output we, output idx, output wdata);
  modport sink (input we, input idx, input wdata);
endinterface

// ----- bench/matrix_factorization_recommender_tb.sv -----
// Testbench of matrix_factorization_recommender: loads ratings and factors,
// issues runs under many register settings and checks every recommendation
// against an in-bench fixed-point gradient descent predictor. Uses mfr_pkg,
// mfr_tb_pkg, mfr_stream_if and mfr_cfg_if.
module matrix_factorization_recommender_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfr_pkg::*;
  import mfr_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfr_cfg_if                          cfg_if ();
  mfr_stream_if #(.data_t(mfr_in_t))  cmd_if ();
  mfr_stream_if #(.data_t(mfr_out_t)) rec_if ();

  matrix_factorization_recommender i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_if.we),
    .cfg_idx_i  (cfg_if.idx),
    .cfg_wdata_i(cfg_if.wdata),
    .in_i       (cmd_if.sink),
    .out_o      (rec_if.source)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: a shadow of every store and register of the block.
  // ---------------------------------------------------------------------
  int   rating_q[NU_MAX*NI_MAX];
  int   ufac_q[NU_MAX*NF_MAX];
  int   ifac_q[NF_MAX*NI_MAX];
  int   pred_q[NU_MAX*NI_MAX];
  int   new_ufac[NU_MAX*NF_MAX];
  int   new_ifac[NF_MAX*NI_MAX];
  int unsigned step_size = 655;
  int unsigned pass_total = 1;
  int unsigned feat_reg = 2;
  int unsigned user_reg = 64;
  int unsigned item_reg = 64;

  // Generation side: which factor entries have been loaded so far, so a run
  // never reads an entry that was never written.
  bit   ufac_loaded[NU_MAX*NF_MAX];
  bit   ifac_loaded[NF_MAX*NI_MAX];

  mfr_in_t  pending_cmds[$];
  mfr_out_t expected_recs[$];

  int  mismatches = 0;
  int  items_taken = 0;
  int  runs_taken = 0;
  int  recs_seen = 0;
  bit  calm = 1'b0;   // phase with no idling on either side
  bit  stim_done = 1'b0;

  // Q16.16 helpers; >>> on a signed longint is a floor shift.
  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int clamp_count(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void form_predictions(int nu, int ni, int nf);
    longint acc;
    for (int i = 0; i < nu; i++)
      for (int j = 0; j < ni; j++) begin
        acc = 0;
        for (int k = 0; k < nf; k++)
          acc += (longint'(ufac_q[i*NF_MAX+k]) * longint'(ifac_q[k*NI_MAX+j])) >>> 16;
        pred_q[i*NI_MAX+j] = sat32(acc);
      end
  endfunction

  function automatic int step_factor(int old, longint g);
    longint lim;
    lim = 64'sd1 <<< 47;
    if (g < -lim) g = -lim;
    if (g > lim - 1) g = lim - 1;
    return sat32(longint'(old) + ((longint'(step_size) * g) >>> 16));
  endfunction

  function automatic void descent_pass(int nu, int ni, int nf);
    longint g, e;
    int r;
    for (int k = 0; k < nf; k++) begin
      for (int j = 0; j < ni; j++) begin
        g = 0;
        for (int i = 0; i < nu; i++) begin
          r = rating_q[i*NI_MAX+j];
          if (r > 0) begin
            e = sat32(longint'(r) - longint'(pred_q[i*NI_MAX+j]));
            g += 2 * ((e * longint'(ufac_q[i*NF_MAX+k])) >>> 16);
          end
        end
        new_ifac[k*NI_MAX+j] = step_factor(ifac_q[k*NI_MAX+j], g);
      end
      for (int i = 0; i < nu; i++) begin
        g = 0;
        for (int j = 0; j < ni; j++) begin
          r = rating_q[i*NI_MAX+j];
          if (r > 0) begin
            e = sat32(longint'(r) - longint'(pred_q[i*NI_MAX+j]));
            g += 2 * ((e * longint'(ifac_q[k*NI_MAX+j])) >>> 16);
          end
        end
        new_ufac[i*NF_MAX+k] = step_factor(ufac_q[i*NF_MAX+k], g);
      end
    end
    for (int k = 0; k < nf; k++) begin
      for (int j = 0; j < ni; j++) ifac_q[k*NI_MAX+j] = new_ifac[k*NI_MAX+j];
      for (int i = 0; i < nu; i++) ufac_q[i*NF_MAX+k] = new_ufac[i*NF_MAX+k];
    end
  endfunction

  // Applies one accepted item to the shadow state; a run queues one
  // recommendation per user in use.
  function automatic void apply_command(mfr_in_t c);
    int nu, ni, nf, best, pick;
    mfr_out_t rec;
    case (c.op)
      OP_WR_RATING: rating_q[c.user_index*NI_MAX + c.item_index] = c.value;
      OP_WR_USER:   ufac_q[c.user_index*NF_MAX + c.feature_index] = c.value;
      OP_WR_ITEM:   ifac_q[c.feature_index*NI_MAX + c.item_index] = c.value;
      default: begin
        nu = clamp_count(user_reg, NU_MAX);
        ni = clamp_count(item_reg, NI_MAX);
        nf = clamp_count(feat_reg, NF_MAX);
        form_predictions(nu, ni, nf);
        for (int unsigned p = 0; p < pass_total; p++) begin
          descent_pass(nu, ni, nf);
          form_predictions(nu, ni, nf);
        end
        for (int i = 0; i < nu; i++) begin
          best = 0;
          pick = 0;
          for (int j = 0; j < ni; j++)
            if (rating_q[i*NI_MAX+j] == 0 && pred_q[i*NI_MAX+j] > best) begin
              best = pred_q[i*NI_MAX+j];
              pick = j;
            end
          rec.user_out = i[5:0];
          rec.recommended_item = pick[5:0];
          rec.last_user = (i == nu - 1);
          expected_recs.push_back(rec);
        end
        runs_taken++;
      end
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued items; predicts each one as it is accepted.
  // ---------------------------------------------------------------------
  int send_gap = 0;
  always @(posedge clk_i) begin
    logic holding;
    logic v_next;
    mfr_in_t d_next;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      holding = cmd_if.valid;
      v_next = cmd_if.valid;
      d_next = cmd_if.data;
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(cmd_if.data);
        items_taken++;
        holding = 1'b0;
        v_next = 1'b0;
        send_gap = pick_gap();
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          d_next = pending_cmds.pop_front();
          v_next = 1'b1;
        end
      end
      cmd_if.valid <= v_next;
      cmd_if.data <= d_next;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted recommendation against the oldest one
  // expected, and stalls the output at random.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk_i) begin
    mfr_out_t want;
    logic r_next;
    if (!rst_ni) begin
      rec_if.ready <= 1'b0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        recs_seen++;
        if (expected_recs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected recommendation user %0d item %0d last %0b",
                     $realtime, rec_if.data.user_out, rec_if.data.recommended_item,
                     rec_if.data.last_user);
        end else begin
          want = expected_recs.pop_front();
          if (want !== rec_if.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected user %0d item %0d last %0b, got %0d %0d %0b",
                       $realtime, want.user_out, want.recommended_item, want.last_user,
                       rec_if.data.user_out, rec_if.data.recommended_item,
                       rec_if.data.last_user);
          end
        end
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        r_next = 1'b0;
      end else begin
        r_next = 1'b1;
      end
      rec_if.ready <= r_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  function automatic int rand_factor();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2:       return int'($urandom_range(255)) - 128;
      default: return int'($urandom_range(32'h40000)) - 32'sh20000;  // about +-2.0
    endcase
  endfunction

  function automatic int rand_rating();
    case ($urandom_range(9))
      0, 1, 2: return 0;                                  // unrated
      3:       return -int'($urandom_range(32'h50000, 1)); // negative: excluded
      4:       return $urandom;
      default: return int'($urandom_range(32'h50000, 32'h10000));
    endcase
  endfunction

  task automatic push_cmd(mfr_op_e op, int u, int it, int f, int v);
    mfr_in_t c;
    c.op = op;
    c.user_index = u[5:0];
    c.item_index = it[5:0];
    c.feature_index = f[2:0];
    c.value = v;
    if (op == OP_WR_USER) ufac_loaded[u*NF_MAX+f] = 1'b1;
    if (op == OP_WR_ITEM) ifac_loaded[f*NI_MAX+it] = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // Blocks until every queued item is taken and every recommendation is in,
  // then lets the block settle. Sampled mid-cycle so driver updates are seen.
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || cmd_if.valid || expected_recs.size() > 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    @(posedge clk_i);
    cfg_if.we <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.wdata <= v[15:0];
    case (idx)
      CFG_LEARNING_RATE:   step_size = v & 16'hffff;
      CFG_ITERATION_COUNT: pass_total = v & 16'hffff;
      CFG_FEATURE_COUNT:   feat_reg = v & 4'hf;
      CFG_USER_COUNT:      user_reg = v & 7'h7f;
      default:             item_reg = v & 7'h7f;
    endcase
  endtask

  // Drains, then writes all five registers.
  task automatic set_config(int unsigned lr, int unsigned it, int unsigned fc,
                            int unsigned uc, int unsigned ic);
    wait_drained();
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_ITERATION_COUNT, it);
    write_reg(CFG_FEATURE_COUNT, fc);
    write_reg(CFG_USER_COUNT, uc);
    write_reg(CFG_ITEM_COUNT, ic);
    @(posedge clk_i);
    cfg_if.we <= 1'b0;
  endtask

  // Random loads, mostly inside the counts in use, then the missing factors
  // and a run command.
  task automatic load_and_run(int nloads);
    int nu, ni, nf, u, it, f;
    nu = clamp_count(user_reg, NU_MAX);
    ni = clamp_count(item_reg, NI_MAX);
    nf = clamp_count(feat_reg, NF_MAX);
    for (int n = 0; n < nloads; n++) begin
      if ($urandom_range(4) == 0) begin
        u = $urandom_range(63);
        it = $urandom_range(63);
        f = $urandom_range(7);
      end else begin
        u = $urandom_range(nu - 1);
        it = $urandom_range(ni - 1);
        f = $urandom_range(nf - 1);
      end
      case ($urandom_range(2))
        0:       push_cmd(OP_WR_RATING, u, it, f, rand_rating());
        1:       push_cmd(OP_WR_USER, u, it, f, rand_factor());
        default: push_cmd(OP_WR_ITEM, u, it, f, rand_factor());
      endcase
    end
    for (int k = 0; k < nf; k++) begin
      for (int i = 0; i < nu; i++)
        if (!ufac_loaded[i*NF_MAX+k])
          push_cmd(OP_WR_USER, i, $urandom_range(63), k, rand_factor());
      for (int j = 0; j < ni; j++)
        if (!ifac_loaded[k*NI_MAX+j])
          push_cmd(OP_WR_ITEM, $urandom_range(63), j, k, rand_factor());
    end
    push_cmd(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(7), $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.we = 1'b0;
    cfg_if.idx = '0;
    cfg_if.wdata = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    rec_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme values, ties, negative and saturated ratings.
    calm = 1'b1;
    set_config(655, 1, 1, 2, 3);
    push_cmd(OP_WR_RATING, 0, 0, 0, 32'sh7fffffff);
    push_cmd(OP_WR_RATING, 1, 1, 0, 32'sh80000000);  // negative, never recommended
    push_cmd(OP_WR_RATING, 1, 2, 0, 32'sh00030000);
    push_cmd(OP_WR_USER, 0, 0, 0, 32'sh7fffffff);
    push_cmd(OP_WR_USER, 1, 0, 0, 32'sh80000000);
    push_cmd(OP_WR_USER, 63, 0, 7, 32'shffffffff);
    push_cmd(OP_WR_ITEM, 0, 0, 0, 32'sh00010000);
    push_cmd(OP_WR_ITEM, 0, 1, 0, 32'sh00010000);      // tie with item 2
    push_cmd(OP_WR_ITEM, 0, 2, 0, 32'sh00010000);
    push_cmd(OP_WR_ITEM, 0, 63, 7, 32'sh7fffffff);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    // Zero iterations and zero counts (treated as 1), feature count clamped.
    set_config(65535, 0, 15, 0, 1);
    load_and_run(2);
    // All-zero factors: no positive prediction, so item 0 everywhere.
    set_config(0, 2, 1, 3, 4);
    for (int i = 0; i < 3; i++) push_cmd(OP_WR_USER, i, 0, 0, 0);
    for (int j = 0; j < 4; j++) push_cmd(OP_WR_ITEM, 0, j, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    // Full-size counts, clamped from above.
    calm = 1'b0;
    set_config(65535, 1, 1, 127, 127);
    load_and_run(6);
    // Maximum pass count on the smallest problem.
    set_config($urandom_range(65535), 65535, 1, 1, 1);
    load_and_run(3);

    // Random phases: small problems with random content.
    while (items_taken + pending_cmds.size() < 350) begin
      calm = ($urandom_range(5) == 0);
      set_config($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4000),
                 $urandom_range(3), $urandom_range(4) == 0 ? $urandom_range(15) : $urandom_range(4, 1),
                 $urandom_range(6, 1), $urandom_range(8, 1));
      load_and_run($urandom_range(30, 8));
    end
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Run covered %0d items, %0d runs and %0d recommendations checked.",
             items_taken, runs_taken, recs_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d recommendations outstanding.", expected_recs.size());
    $display("Mismatches found");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/mfr_pkg.sv
sv/mfr_stream_if.sv
sv/mfr_ram.sv
sv/mfr_mac.sv
sv/matrix_factorization_recommender.sv
bench/mfr_tb_pkg.sv
bench/mfr_tb_if.sv
bench/matrix_factorization_recommender_tb.sv
